[src/sas_pkg.sv]
// shared types and constants of the sprite animation sequencer
package sas_pkg;

    // default position and bounds
    localparam logic signed [15:0] DEF_INIT_X = 16'sd100;
    localparam logic signed [15:0] DEF_INIT_Y = 16'sd100;
    localparam logic signed [15:0] DEF_MIN_X  = 16'sd0;
    localparam logic signed [15:0] DEF_MAX_X  = 16'sd200;
    localparam logic signed [15:0] DEF_MIN_Y  = 16'sd0;
    localparam logic signed [15:0] DEF_MAX_Y  = 16'sd200;

    // register file
    localparam int                 ADDR_W           = 5;
    localparam logic        [15:0] DURATION_RST_VAL = 16'd100;

    typedef enum logic [2:0] {
        REG_FRAME_COUNT    = 3'd0,
        REG_FRAME_DURATION = 3'd1,
        REG_MAX_LOOPS      = 3'd2,
        REG_MOVES_SPRITE   = 3'd3,
        REG_STEP_X         = 3'd4,
        REG_STEP_Y         = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] now_ms;
        logic [7:0]  action_id;
        logic        restart;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         frame_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               frame_dirty;
        logic               pos_dirty;
        logic               finished;
    } t_out_word;

endpackage

[src/sprite_animation_sequencer.sv]
// sprite animation sequencer: command decode, frame timer, loop count and clamped motion
//
// Every command word gives exactly one result word, which shows the frame index, the
// position, the dirty flags and the finished flag after the command has acted. A word
// is taken into an input register, is worked by one pass of compare, add and clamp logic
// against the sequencer state once the result register is free, and lands in the result
// register together with the state update. One word is taken per cycle for as long as
// the result side keeps up; a stalled result holds while the input register still takes
// one more word. The timer compares (now_ms - last tick) modulo 2^32 with frame_duration_ms.
// The action is defined by the APB registers (frame_count, frame_duration_ms, max_loops,
// moves_sprite, step_x, step_y at byte addresses 0x00 to 0x14); write them only while no
// word is in flight. Position bounds and the home position are set by the module parameters.
module sprite_animation_sequencer #(
    parameter logic signed [15:0] INIT_X = sas_pkg::DEF_INIT_X,
    parameter logic signed [15:0] INIT_Y = sas_pkg::DEF_INIT_Y,
    parameter logic signed [15:0] MIN_X  = sas_pkg::DEF_MIN_X,
    parameter logic signed [15:0] MAX_X  = sas_pkg::DEF_MAX_X,
    parameter logic signed [15:0] MIN_Y  = sas_pkg::DEF_MIN_Y,
    parameter logic signed [15:0] MAX_Y  = sas_pkg::DEF_MAX_Y
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command words
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  sas_pkg::t_in_word           i_in_data,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output sas_pkg::t_out_word          o_out_data,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sas_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // clamp a position plus a signed step, lower bound first then upper bound
    function automatic logic signed [15:0] f_clamp(
        input logic signed [15:0] cur,
        input logic signed [7:0]  step,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [16:0] v;
        logic signed [16:0] lo_e;
        logic signed [16:0] hi_e;
        lo_e = $signed({lo[15], lo});
        hi_e = $signed({hi[15], hi});
        v    = $signed({cur[15], cur}) + $signed({{9{step[7]}}, step});
        if (v < lo_e) begin
            v = lo_e;
        end
        if (v > hi_e) begin
            v = hi_e;
        end
        return v[15:0];
    endfunction

    // configuration registers
    logic [7:0]         r_frame_count;
    logic [15:0]        r_frame_duration;
    logic [7:0]         r_max_loops;
    logic               r_moves_sprite;
    logic signed [7:0]  r_step_x;
    logic signed [7:0]  r_step_y;

    // sequencer state
    logic               r_active,      n_active;
    logic [7:0]         r_active_id,   n_active_id;
    logic [7:0]         r_frame_idx,   n_frame_idx;
    logic [7:0]         r_loops_done,  n_loops_done;
    logic [31:0]        r_last_tick,   n_last_tick;
    logic               r_seeded,      n_seeded;
    logic signed [15:0] r_cur_x,       n_cur_x;
    logic signed [15:0] r_cur_y,       n_cur_y;
    logic               r_dirty_frame, n_dirty_frame;
    logic               r_dirty_pos,   n_dirty_pos;

    // input register and result register
    logic               r_in_valid;
    sas_pkg::t_in_word  r_in;
    logic               r_out_valid;
    sas_pkg::t_out_word r_out;
    sas_pkg::t_out_word n_out;

    logic               w_advance;
    logic               w_cfg_wr;
    sas_pkg::t_reg_idx  w_reg_idx;

    // result register frees when empty or being taken
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = sas_pkg::t_reg_idx'(paddr[sas_pkg::ADDR_W-1:2]);

    // register read back
    always_comb begin
        unique case (w_reg_idx)
            sas_pkg::REG_FRAME_COUNT:    prdata = {24'd0, r_frame_count};
            sas_pkg::REG_FRAME_DURATION: prdata = {16'd0, r_frame_duration};
            sas_pkg::REG_MAX_LOOPS:      prdata = {24'd0, r_max_loops};
            sas_pkg::REG_MOVES_SPRITE:   prdata = {31'd0, r_moves_sprite};
            sas_pkg::REG_STEP_X:         prdata = {24'd0, r_step_x};
            sas_pkg::REG_STEP_Y:         prdata = {24'd0, r_step_y};
            default:                     prdata = 32'd0;
        endcase
    end

    // command processing for the word in the input register
    always_comb begin
        logic [7:0]  next_idx;
        logic [7:0]  loops;
        logic        limit_now;
        logic        limit_new;
        logic signed [15:0] nx;
        logic signed [15:0] ny;

        n_active      = r_active;
        n_active_id   = r_active_id;
        n_frame_idx   = r_frame_idx;
        n_loops_done  = r_loops_done;
        n_last_tick   = r_last_tick;
        n_seeded      = r_seeded;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_dirty_frame = r_dirty_frame;
        n_dirty_pos   = r_dirty_pos;

        limit_now = (r_max_loops != 8'd0) && (r_loops_done >= r_max_loops);
        next_idx  = r_frame_idx + 8'd1;
        loops     = r_loops_done;
        if (next_idx >= r_frame_count) begin
            next_idx = 8'd0;
            if (r_loops_done != 8'hFF) begin
                loops = r_loops_done + 8'd1;
            end
        end
        limit_new = (r_max_loops != 8'd0) && (loops >= r_max_loops);
        nx = f_clamp(r_cur_x, r_step_x, MIN_X, MAX_X);
        ny = f_clamp(r_cur_y, r_step_y, MIN_Y, MAX_Y);

        case (r_in.command)
            sas_pkg::CMD_TICK: begin
                if (r_active && (r_frame_count != 8'd0) && !limit_now) begin
                    if (!r_seeded) begin
                        // first tick only seeds the timer
                        n_last_tick   = r_in.now_ms;
                        n_seeded      = 1'b1;
                        n_dirty_frame = 1'b1;
                    end else if ((r_in.now_ms - r_last_tick) >= {16'd0, r_frame_duration})
                    begin
                        n_last_tick   = r_in.now_ms;
                        n_frame_idx   = next_idx;
                        n_loops_done  = loops;
                        n_dirty_frame = 1'b1;
                        if (r_moves_sprite && !limit_new &&
                            ((nx != r_cur_x) || (ny != r_cur_y))) begin
                            n_cur_x     = nx;
                            n_cur_y     = ny;
                            n_dirty_pos = 1'b1;
                        end
                    end
                end
            end
            sas_pkg::CMD_START: begin
                if (r_in.restart || !r_active || (r_active_id != r_in.action_id)) begin
                    n_active      = 1'b1;
                    n_active_id   = r_in.action_id;
                    n_frame_idx   = 8'd0;
                    n_loops_done  = 8'd0;
                    n_last_tick   = 32'd0;
                    n_seeded      = 1'b0;
                    n_dirty_frame = 1'b1;
                end
            end
            sas_pkg::CMD_CLEAR: begin
                n_dirty_frame = 1'b0;
                n_dirty_pos   = 1'b0;
            end
            default: begin
                // home: back to the start position with no action
                n_active      = 1'b0;
                n_active_id   = 8'd0;
                n_frame_idx   = 8'd0;
                n_loops_done  = 8'd0;
                n_last_tick   = 32'd0;
                n_seeded      = 1'b0;
                n_cur_x       = INIT_X;
                n_cur_y       = INIT_Y;
                n_dirty_frame = 1'b1;
                n_dirty_pos   = 1'b0;
            end
        endcase

        n_out.frame_index = n_frame_idx;
        n_out.pos_x       = n_cur_x;
        n_out.pos_y       = n_cur_y;
        n_out.frame_dirty = n_dirty_frame;
        n_out.pos_dirty   = n_dirty_pos;
        n_out.finished    = !n_active ||
                            ((r_max_loops != 8'd0) && (n_loops_done >= r_max_loops));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count    <= 8'd0;
            r_frame_duration <= sas_pkg::DURATION_RST_VAL;
            r_max_loops      <= 8'd0;
            r_moves_sprite   <= 1'b0;
            r_step_x         <= 8'sd0;
            r_step_y         <= 8'sd0;
            r_active         <= 1'b0;
            r_active_id      <= 8'd0;
            r_frame_idx      <= 8'd0;
            r_loops_done     <= 8'd0;
            r_last_tick      <= 32'd0;
            r_seeded         <= 1'b0;
            r_cur_x          <= INIT_X;
            r_cur_y          <= INIT_Y;
            r_dirty_frame    <= 1'b1;
            r_dirty_pos      <= 1'b0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    sas_pkg::REG_FRAME_COUNT:    r_frame_count    <= pwdata[7:0];
                    sas_pkg::REG_FRAME_DURATION: r_frame_duration <= pwdata[15:0];
                    sas_pkg::REG_MAX_LOOPS:      r_max_loops      <= pwdata[7:0];
                    sas_pkg::REG_MOVES_SPRITE:   r_moves_sprite   <= pwdata[0];
                    sas_pkg::REG_STEP_X:         r_step_x         <= $signed(pwdata[7:0]);
                    sas_pkg::REG_STEP_Y:         r_step_y         <= $signed(pwdata[7:0]);
                    default: begin
                    end
                endcase
            end

            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_out         <= n_out;
                    r_active      <= n_active;
                    r_active_id   <= n_active_id;
                    r_frame_idx   <= n_frame_idx;
                    r_loops_done  <= n_loops_done;
                    r_last_tick   <= n_last_tick;
                    r_seeded      <= n_seeded;
                    r_cur_x       <= n_cur_x;
                    r_cur_y       <= n_cur_y;
                    r_dirty_frame <= n_dirty_frame;
                    r_dirty_pos   <= n_dirty_pos;
                end
            end

            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in <= i_in_data;
                end
            end
        end
    end

    // a home command leaves the sprite at rest with no action
    a_home_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance && (r_in.command == sas_pkg::CMD_RESET)) |=>
        (o_out_valid && (o_out_data.pos_x == INIT_X) && (o_out_data.pos_y == INIT_Y) &&
         o_out_data.frame_dirty && !o_out_data.pos_dirty && o_out_data.finished))
        else $error("home command result wrong");

    // a clear command leaves both dirty flags low
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance && (r_in.command == sas_pkg::CMD_CLEAR)) |=>
        (o_out_valid && !o_out_data.frame_dirty && !o_out_data.pos_dirty))
        else $error("clear command left dirty flags");

    // the input side only stalls with a full input register
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a pending word");

    // motion other than homing always marks the position dirty
    a_move_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance && (r_in.command == sas_pkg::CMD_TICK) &&
         ((n_cur_x != r_cur_x) || (n_cur_y != r_cur_y))) |=> r_dirty_pos)
        else $error("position moved without dirty flag");

endmodule

[tb/sprite_animation_sequencer_tb.sv]
// self-checking testbench of the sprite animation sequencer, with a predictor and random traffic
module sprite_animation_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // a cycle with no handshake at all counts toward the watchdog
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 250;
    localparam int PRINT_LIMIT = 100;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    sas_pkg::t_in_word          in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    sas_pkg::t_out_word         out_data;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [sas_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                pwdata    = '0;
    logic [31:0]                prdata;
    logic                       pready;

    sprite_animation_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // command words waiting to be offered, result words still owed by the block
    sas_pkg::t_in_word  cmd_words[$];
    sas_pkg::t_out_word expected_views[$];

    int   mismatches = 0;
    int   words_seen = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    int   quiet      = 0;
    // no random idling on either side while set
    logic calm       = 1'b0;

    // predictor copy of the action registers
    logic        [7:0]  cfg_frames;
    logic        [15:0] cfg_dur;
    logic        [7:0]  cfg_loops;
    logic               cfg_moves;
    logic signed [7:0]  cfg_dx;
    logic signed [7:0]  cfg_dy;

    // predictor copy of the sequencer state
    logic               playing;
    logic        [7:0]  playing_id;
    logic        [7:0]  frame_no;
    logic        [7:0]  loops_done;
    logic        [31:0] last_tick;
    logic               timer_seeded;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic               frame_chg;
    logic               pos_chg;

    // loop limit set and reached means the animation is frozen
    function automatic logic loop_limit_hit();
        return (cfg_loops != 8'd0) && (loops_done >= cfg_loops);
    endfunction

    // lower bound first, then upper, so an inverted pair lands on the upper
    function automatic logic signed [15:0] clamp_axis(input int v, input int lo, input int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return 16'(v);
    endfunction

    function automatic void go_home();
        playing      = 1'b0;
        playing_id   = 8'd0;
        frame_no     = 8'd0;
        loops_done   = 8'd0;
        last_tick    = 32'd0;
        timer_seeded = 1'b0;
        x_pos        = sas_pkg::DEF_INIT_X;
        y_pos        = sas_pkg::DEF_INIT_Y;
        frame_chg    = 1'b1;
        pos_chg      = 1'b0;
    endfunction

    // applies one command word to the predicted state and returns the view after it
    function automatic sas_pkg::t_out_word sequence_cmd(input sas_pkg::t_in_word w);
        sas_pkg::t_out_word v;
        logic        [31:0] elapsed;
        logic        [7:0]  next_frame;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        case (w.command)
            sas_pkg::CMD_TICK: begin
                if (playing && cfg_frames != 8'd0 && !loop_limit_hit()) begin
                    if (!timer_seeded) begin
                        // first tick only seeds the timer, zero is a valid seed
                        last_tick    = w.now_ms;
                        timer_seeded = 1'b1;
                        frame_chg    = 1'b1;
                    end else begin
                        // modulo 2^32 so the timer survives a wrap of now_ms
                        elapsed = w.now_ms - last_tick;
                        if (elapsed >= {16'd0, cfg_dur}) begin
                            last_tick  = w.now_ms;
                            next_frame = frame_no + 8'd1;
                            if (next_frame >= cfg_frames) begin
                                next_frame = 8'd0;
                                if (loops_done != 8'hFF) loops_done++;
                            end
                            // no motion on the advance that reaches the limit
                            if (cfg_moves && !loop_limit_hit()) begin
                                nx = clamp_axis(int'(x_pos) + int'(cfg_dx),
                                                int'(sas_pkg::DEF_MIN_X),
                                                int'(sas_pkg::DEF_MAX_X));
                                ny = clamp_axis(int'(y_pos) + int'(cfg_dy),
                                                int'(sas_pkg::DEF_MIN_Y),
                                                int'(sas_pkg::DEF_MAX_Y));
                                if (nx != x_pos || ny != y_pos) begin
                                    x_pos   = nx;
                                    y_pos   = ny;
                                    pos_chg = 1'b1;
                                end
                            end
                            frame_no  = next_frame;
                            frame_chg = 1'b1;
                        end
                    end
                end
            end
            sas_pkg::CMD_START: begin
                // same action still active without restart is a no-op
                if (w.restart || !playing || playing_id != w.action_id) begin
                    playing      = 1'b1;
                    playing_id   = w.action_id;
                    frame_no     = 8'd0;
                    loops_done   = 8'd0;
                    last_tick    = 32'd0;
                    timer_seeded = 1'b0;
                    frame_chg    = 1'b1;
                end
            end
            sas_pkg::CMD_CLEAR: begin
                frame_chg = 1'b0;
                pos_chg   = 1'b0;
            end
            sas_pkg::CMD_RESET: begin
                go_home();
            end
        endcase
        v.frame_index = frame_no;
        v.pos_x       = x_pos;
        v.pos_y       = y_pos;
        v.frame_dirty = frame_chg;
        v.pos_dirty   = pos_chg;
        v.finished    = !playing || loop_limit_hit();
        return v;
    endfunction

    function automatic void push_cmd(input sas_pkg::t_cmd c, input logic [31:0] ms,
                                     input logic [7:0] id, input logic rs);
        sas_pkg::t_in_word w;
        w.command   = c;
        w.now_ms    = ms;
        w.action_id = id;
        w.restart   = rs;
        cmd_words.push_back(w);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch on %s at %0t: got %0h expected %0h", what, $realtime, got, want);
        mismatches++;
    endtask

    // setup cycle, access cycle, written on the edge that closes the access
    task automatic write_reg(input sas_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sas_pkg::REG_FRAME_COUNT:    cfg_frames = value[7:0];
            sas_pkg::REG_FRAME_DURATION: cfg_dur    = value[15:0];
            sas_pkg::REG_MAX_LOOPS:      cfg_loops  = value[7:0];
            sas_pkg::REG_MOVES_SPRITE:   cfg_moves  = value[0];
            sas_pkg::REG_STEP_X:         cfg_dx     = value[7:0];
            sas_pkg::REG_STEP_Y:         cfg_dy     = value[7:0];
            default: ;
        endcase
    endtask

    // rewrites the whole action definition, ends on a falling edge
    task automatic load_setting(input logic [7:0] frames, input logic [15:0] dur,
                                input logic [7:0] loops, input logic moves,
                                input logic [7:0] dx, input logic [7:0] dy);
        write_reg(sas_pkg::REG_FRAME_COUNT,    {24'd0, frames});
        write_reg(sas_pkg::REG_FRAME_DURATION, {16'd0, dur});
        write_reg(sas_pkg::REG_MAX_LOOPS,      {24'd0, loops});
        write_reg(sas_pkg::REG_MOVES_SPRITE,   {31'd0, moves});
        write_reg(sas_pkg::REG_STEP_X,         {24'd0, dx});
        write_reg(sas_pkg::REG_STEP_Y,         {24'd0, dy});
        @(negedge i_clk);
    endtask

    // every command word owes one result word, so empty queues mean idle
    task automatic drain();
        do @(negedge i_clk);
        while (cmd_words.size() != 0 || in_valid || expected_views.size() != 0);
    endtask

    // mostly ticks on a running clock stepped around the frame duration,
    // with starts, clears, resets and jumps of the clock mixed in
    task automatic queue_random_words(input int count);
        sas_pkg::t_in_word w;
        logic [31:0]       clock_ms;
        int                pick;
        clock_ms = $urandom();
        repeat (count) begin
            pick        = int'($urandom_range(99));
            w.now_ms    = $urandom();
            w.action_id = 8'($urandom_range(255));
            w.restart   = 1'($urandom_range(1));
            if (pick < 78) begin
                w.command = sas_pkg::CMD_TICK;
                clock_ms += $urandom_range(2 * int'(cfg_dur) + 2);
                w.now_ms  = clock_ms;
            end else if (pick < 84) begin
                // a small id pool so the same action is often started again
                w.command = sas_pkg::CMD_START;
                if (pick < 82) w.action_id = 8'($urandom_range(3));
            end else if (pick < 90) begin
                w.command = sas_pkg::CMD_CLEAR;
            end else if (pick < 92) begin
                w.command = sas_pkg::CMD_RESET;
            end else begin
                // tick far off the running clock, the clock follows it
                w.command = sas_pkg::CMD_TICK;
                clock_ms  = w.now_ms;
            end
            cmd_words.push_back(w);
        end
    endtask

    // driver: holds a stalled word, offers the next one or idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) expected_views.push_back(sequence_cmd(in_data));
            if (!in_valid || !in_stall) begin
                if (cmd_words.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
                    in_data  <= cmd_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest expected view
    sas_pkg::t_out_word want;

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            words_seen++;
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected result word", 32'(out_data), 32'd0);
            end else begin
                want = expected_views.pop_front();
                if (out_data.frame_index !== want.frame_index)
                    report_mismatch("frame_index", 32'(out_data.frame_index),
                                    32'(want.frame_index));
                if (out_data.pos_x !== want.pos_x)
                    report_mismatch("pos_x", 32'(out_data.pos_x), 32'(want.pos_x));
                if (out_data.pos_y !== want.pos_y)
                    report_mismatch("pos_y", 32'(out_data.pos_y), 32'(want.pos_y));
                if (out_data.frame_dirty !== want.frame_dirty)
                    report_mismatch("frame_dirty", 32'(out_data.frame_dirty),
                                    32'(want.frame_dirty));
                if (out_data.pos_dirty !== want.pos_dirty)
                    report_mismatch("pos_dirty", 32'(out_data.pos_dirty),
                                    32'(want.pos_dirty));
                if (out_data.finished !== want.finished)
                    report_mismatch("finished", 32'(out_data.finished),
                                    32'(want.finished));
            end
        end
        // one long hold-off while plenty of words wait, so the block backs up
        if (!hold_done && cmd_words.size() > 50 && words_seen > 20) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 37);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        int          phase;
        logic [7:0]  r_frames;
        logic [15:0] r_dur;
        logic [7:0]  r_loops;

        cfg_frames = 8'd0;
        cfg_dur    = sas_pkg::DURATION_RST_VAL;
        cfg_loops  = 8'd0;
        cfg_moves  = 1'b0;
        cfg_dx     = 8'sd0;
        cfg_dy     = 8'sd0;
        go_home();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values: no frames, so nothing seeds or animates
        push_cmd(sas_pkg::CMD_TICK,  32'd50,        8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_START, 32'hFFFF_FFFF, 8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd0,         8'hFF,  1'b1);
        push_cmd(sas_pkg::CMD_CLEAR, 32'd0,         8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_RESET, 32'd0,         8'd0,   1'b0);
        drain();

        // three frames, two loops, steps at both extremes hit the clamps
        load_setting(8'd3, 16'd10, 8'd2, 1'b1, 8'h7F, 8'h80);
        push_cmd(sas_pkg::CMD_START, 32'd0,         8'hFF,  1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd0,         8'd0,   1'b0);   // seed at time zero
        push_cmd(sas_pkg::CMD_TICK,  32'd9,         8'd0,   1'b0);   // one short
        push_cmd(sas_pkg::CMD_TICK,  32'd10,        8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd20,        8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_CLEAR, 32'd0,         8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd30,        8'd0,   1'b0);   // wrap, first loop
        push_cmd(sas_pkg::CMD_START, 32'd0,         8'hFF,  1'b0);   // same action, ignored
        push_cmd(sas_pkg::CMD_TICK,  32'd40,        8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd50,        8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd60,        8'd0,   1'b0);   // limit reached, frozen
        push_cmd(sas_pkg::CMD_TICK,  32'd70,        8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_START, 32'd0,         8'hFF,  1'b1);   // forced restart
        push_cmd(sas_pkg::CMD_TICK,  32'hFFFF_FFF8, 8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd2,         8'd0,   1'b0);   // elapsed across wrap
        push_cmd(sas_pkg::CMD_RESET, 32'd0,         8'd0,   1'b0);
        drain();

        // widest frame count and duration, endless loops
        load_setting(8'hFF, 16'hFFFF, 8'd0, 1'b1, 8'h80, 8'h7F);
        push_cmd(sas_pkg::CMD_START, 32'd0,         8'd1,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd0,         8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd65534,     8'd0,   1'b0);
        push_cmd(sas_pkg::CMD_TICK,  32'd65535,     8'd0,   1'b0);
        drain();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_setting(8'hFF, 16'hFFFF, 8'hFF, 1'b1, 8'h7F, 8'h7F);
                1: load_setting(8'd1, 16'd0, 8'd0, 1'b1, 8'h80, 8'h80);
                default: begin
                    case ($urandom_range(3))
                        0:       r_frames = 8'd1;
                        1:       r_frames = 8'($urandom_range(2, 5));
                        2:       r_frames = 8'($urandom_range(6, 20));
                        default: r_frames = 8'($urandom_range(255));
                    endcase
                    case ($urandom_range(3))
                        0:       r_dur = 16'd0;
                        1:       r_dur = 16'($urandom_range(1, 20));
                        2:       r_dur = 16'($urandom_range(21, 1000));
                        default: r_dur = 16'($urandom_range(65535));
                    endcase
                    case ($urandom_range(3))
                        0:       r_loops = 8'd0;
                        1:       r_loops = 8'($urandom_range(1, 4));
                        2:       r_loops = 8'($urandom_range(5, 255));
                        default: r_loops = 8'd1;
                    endcase
                    load_setting(r_frames, r_dur, r_loops, 1'($urandom_range(1)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
                end
            endcase
            calm = (phase == 3);
            queue_random_words(PHASE_WORDS);
            drain();
        end

        // settle before the verdict
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
